[rtl/ldpcbf_pkg.sv]
// Shared types and constants of the LDPC bit-flipping decoder.
package ldpcbf_pkg;

  localparam int DataW = 64;
  localparam int RowIdxW = 5;
  localparam int IterW = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [IterW-1:0] MAX_ITER_RESET = 8'd10;

  typedef struct packed {
    logic               opcode;
    logic [RowIdxW-1:0] row_index;
    logic [DataW-1:0]   data_word;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] decoded_word;
    logic             syndrome_clear;
    logic [IterW-1:0] iterations_used;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SYN,
    S_CHECK,
    S_COUNT,
    S_SCAN,
    S_FLIP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load_word;
    logic syn_acc;
    logic count_clear;
    logic count_acc;
    logic scan_acc;
    logic flip;
  } ctrl_t;

endpackage

[rtl/ldpc_bit_flip_decoder.sv]
// Top level of the hard-decision LDPC bit-flipping decoder.
//
// The input channel (in_valid_i / in_ready_o / in_data_i) carries two kinds
// of item. A load item writes one parity-check row into the row memory and
// produces no result; a row index at or beyond CHECK_COUNT is dropped. A
// decode item carries a received word and produces exactly one result item on
// the output channel (out_valid_o / out_ready_i / out_data_o): the corrected
// word, a flag that all checks are satisfied, and the iterations used.
// Every row must have been loaded before the first decode.
// The configuration channel writes max_iterations and is always ready; the
// user must write it only while the decoder is idle; the block does not
// enforce this. Reset sets the limit to 10, empties the output register and
// returns the sequencer to idle. Row contents are not cleared by reset.
// A decode item runs one syndrome pass and one decision step, and each
// flipping iteration a count pass, a scan for the largest count, a flip and
// a new syndrome pass with its decision step; then the result is handed to
// the output register. Every pass reads the row memory once per row, so the
// single read port sets the length of the syndrome and count passes, and the
// search for the largest count visits one counter per cycle. One decode runs
// at a time. A stalled receiver holds the result in the output register; load
// items are still taken meanwhile, and a following decode waits at its end for
// the register to free up.
module ldpc_bit_flip_decoder #(
  parameter int CODE_LENGTH = 64,
  parameter int CHECK_COUNT = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ldpcbf_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ldpcbf_pkg::out_item_t out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            cfg_data_i
);
  import ldpcbf_pkg::*;

  localparam int AddrW = (CHECK_COUNT > 1) ? $clog2(CHECK_COUNT) : 1;
  localparam int ScanW = $clog2(CODE_LENGTH);
  localparam int Span = (CHECK_COUNT + 1 > CODE_LENGTH) ? CHECK_COUNT + 1 : CODE_LENGTH;
  localparam int CW = $clog2(Span + 1);

  state_e state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic [IterW-1:0] max_iter_q;
  logic             rd_vld_q;
  logic [AddrW-1:0] rd_row_q;
  logic             out_valid_q;
  out_item_t        out_data_q;

  logic             in_fire;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic             out_load;
  ctrl_t            ctrl;
  logic [CODE_LENGTH-1:0] row_data;
  logic [CODE_LENGTH-1:0] word;
  logic             syn_zero;

  assign in_fire = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign rd_addr = cnt_q[AddrW-1:0];

  // Next-state logic of the decode sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (in_data_i.opcode == OP_DECODE)) begin
          state_d = S_SYN;
        end
      end
      S_SYN: begin
        if (cnt_q == CW'(CHECK_COUNT)) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (syn_zero || (iter_q >= max_iter_q)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_COUNT;
        end
      end
      S_COUNT: begin
        if (cnt_q == CW'(CHECK_COUNT)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q == CW'(CODE_LENGTH - 1)) begin
          state_d = S_FLIP;
        end
      end
      S_FLIP: begin
        state_d = S_SYN;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: handshakes, memory access and datapath controls.
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    rd_en = ((state_q == S_SYN) || (state_q == S_COUNT)) && (cnt_q < CW'(CHECK_COUNT));
    wr_en = in_fire && (in_data_i.opcode == OP_LOAD) &&
            (32'(in_data_i.row_index) < CHECK_COUNT);
    ctrl.load_word = in_fire && (in_data_i.opcode == OP_DECODE);
    ctrl.syn_acc = rd_vld_q && (state_q == S_SYN);
    ctrl.count_clear = (state_q == S_CHECK);
    ctrl.count_acc = rd_vld_q && (state_q == S_COUNT);
    ctrl.scan_acc = (state_q == S_SCAN);
    ctrl.flip = (state_q == S_FLIP);
    out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  end

  // The step counter restarts whenever the sequencer moves to a new phase.
  always_comb begin
    if (state_d != state_q) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_comb begin
    iter_d = iter_q;
    if (ctrl.load_word) begin
      iter_d = '0;
    end else if (ctrl.flip) begin
      iter_d = iter_q + IterW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      iter_q <= '0;
      max_iter_q <= MAX_ITER_RESET;
      rd_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      iter_q <= iter_d;
      rd_vld_q <= rd_en;
      if (cfg_valid_i && cfg_ready_o) begin
        max_iter_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Row index of the data that the memory returns, and the result payload.
  always_ff @(posedge clk_i) begin
    rd_row_q <= rd_addr;
    if (out_load) begin
      out_data_q.decoded_word <= DataW'(word);
      out_data_q.syndrome_clear <= syn_zero;
      out_data_q.iterations_used <= iter_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

  ldpcbf_row_mem #(
    .Width(CODE_LENGTH),
    .Depth(CHECK_COUNT)
  ) u_row_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AddrW'(in_data_i.row_index)),
    .wr_data_i (in_data_i.data_word[CODE_LENGTH-1:0]),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (row_data)
  );

  ldpcbf_engine #(
    .CodeLen(CODE_LENGTH),
    .CheckCnt(CHECK_COUNT)
  ) u_engine (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .word_i     (in_data_i.data_word[CODE_LENGTH-1:0]),
    .row_data_i (row_data),
    .row_idx_i  (rd_row_q),
    .scan_idx_i (cnt_q[ScanW-1:0]),
    .word_o     (word),
    .syn_zero_o (syn_zero)
  );

  // Returned row data always belongs to a row that exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (32'(rd_row_q) < CHECK_COUNT))
    else $error("row memory read beyond the last check row");

  // Each flip counts exactly one iteration and starts a new syndrome pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLIP) |=> (state_q == S_SYN) && (iter_q == $past(iter_q) + IterW'(1)))
    else $error("flip did not advance the iteration count");

  // A satisfied syndrome ends the decode at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) && syn_zero |=> (state_q == S_DONE))
    else $error("decode continued after a clear syndrome");

endmodule

[rtl/ldpcbf_row_mem.sv]
// Parity-check row memory with one write port and one registered read port.
module ldpcbf_row_mem #(
  parameter int Width = 64,
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

  // Rows are loaded only while no decode is running.
  assert property (@(posedge clk_i) !(wr_en_i && rd_en_i))
    else $error("row memory written and read in the same cycle");

endmodule

[rtl/ldpcbf_engine.sv]
// Word, syndrome, per-bit counters and flip logic of the decoder.
module ldpcbf_engine #(
  parameter int CodeLen = 64,
  parameter int CheckCnt = 32,
  localparam int RowAW = (CheckCnt > 1) ? $clog2(CheckCnt) : 1,
  localparam int ScanW = $clog2(CodeLen)
) (
  input  logic                 clk_i,
  input  ldpcbf_pkg::ctrl_t    ctrl_i,
  input  logic [CodeLen-1:0]   word_i,
  input  logic [CodeLen-1:0]   row_data_i,
  input  logic [RowAW-1:0]     row_idx_i,
  input  logic [ScanW-1:0]     scan_idx_i,
  output logic [CodeLen-1:0]   word_o,
  output logic                 syn_zero_o
);
  import ldpcbf_pkg::*;

  localparam int CntW = $clog2(CheckCnt + 1);

  logic [CodeLen-1:0]  word_q;
  logic [CheckCnt-1:0] syn_q;
  logic [CntW-1:0]     count_q [CodeLen];
  logic [CntW-1:0]     best_q;
  logic [CntW-1:0]     scan_val;
  logic [CodeLen-1:0]  flips;

  assign scan_val = count_q[scan_idx_i];

  always_comb begin
    for (int i = 0; i < CodeLen; i++) begin
      flips[i] = (count_q[i] >= best_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_word) begin
      word_q <= word_i;
    end else if (ctrl_i.flip) begin
      word_q <= word_q ^ flips;
    end

    if (ctrl_i.syn_acc) begin
      syn_q[row_idx_i] <= ^(word_q & row_data_i);
    end

    for (int i = 0; i < CodeLen; i++) begin
      if (ctrl_i.count_clear) begin
        count_q[i] <= '0;
      end else if (ctrl_i.count_acc && syn_q[row_idx_i] && row_data_i[i]) begin
        count_q[i] <= count_q[i] + CntW'(1);
      end
    end

    if (ctrl_i.count_clear) begin
      best_q <= '0;
    end else if (ctrl_i.scan_acc && (scan_val > best_q)) begin
      best_q <= scan_val;
    end
  end

  assign word_o = word_q;
  assign syn_zero_o = (syn_q == '0);

endmodule

[dv/ldpc_bit_flip_decoder_test.sv]
// Self-checking testbench for the LDPC bit-flipping decoder with a scoreboard class.
`timescale 1ns / 1ps

module ldpc_bit_flip_decoder_test;

  import ldpcbf_pkg::*;

  // The block is built with its default sizes, and the predictor uses the same ones.
  localparam int CodeLen = 64;
  localparam int CheckCnt = 32;
  localparam logic [DataW-1:0] WordMask = {DataW{1'b1}} >> (DataW - CodeLen);

  // A decode needs a syndrome pass, a decision step and one flipping round per
  // iteration. The slowest single decode therefore runs at the largest limit of 255.
  // The watchdog allows several times that stretch without any handshake.
  localparam int SyndromeCycles = CheckCnt + 2;
  localparam int RoundCycles = 2 * CheckCnt + CodeLen + 4;
  localparam int SlowestDecode = SyndromeCycles + RoundCycles * 255 + 1;
  localparam int StallLimit = 4 * (SlowestDecode + 64);

  // A load is written to the row memory as soon as it is accepted, so a settle of
  // SettleCycles after the last result is enough before the limit register is touched.
  localparam int SettleCycles = 8;
  localparam int DrainCycles = 100;
  localparam int NumPhases = 12;
  localparam int PhaseItems = 68;
  localparam int MaxPrinted = 100;

  // The scoreboard keeps its own copy of the parity-check matrix and of the
  // iteration limit. It predicts each decode when the item is accepted and then
  // compares the results in order as they leave the block.
  class decode_scoreboard;
    logic [DataW-1:0] rows [CheckCnt];
    logic [IterW-1:0] limit;
    out_item_t        awaited[$];
    int unsigned      mismatches;

    function new();
      limit = MAX_ITER_RESET;
      mismatches = 0;
      foreach (rows[r]) rows[r] = '0;
    endfunction

    function void set_limit(logic [IterW-1:0] value);
      limit = value;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // Bit r is set when check r is unsatisfied by the word.
    function logic [CheckCnt-1:0] syndrome(logic [DataW-1:0] word);
      logic [CheckCnt-1:0] syn;
      for (int r = 0; r < CheckCnt; r++) syn[r] = ^(word & rows[r]);
      return syn;
    endfunction

    // A position is flipped when the number of unsatisfied checks that contain it
    // reaches the largest such number over the whole word.
    function logic [DataW-1:0] flip_worst(logic [DataW-1:0] word, logic [CheckCnt-1:0] syn);
      int unsigned      hits [CodeLen];
      int unsigned      best;
      logic [DataW-1:0] flips;
      best = 0;
      flips = '0;
      for (int i = 0; i < CodeLen; i++) begin
        hits[i] = 0;
        for (int r = 0; r < CheckCnt; r++) begin
          if (syn[r] && rows[r][i]) hits[i]++;
        end
        if (hits[i] > best) best = hits[i];
      end
      for (int i = 0; i < CodeLen; i++) begin
        if (hits[i] >= best) flips[i] = 1'b1;
      end
      return (word ^ flips) & WordMask;
    endfunction

    function void note_input(in_item_t item);
      logic [DataW-1:0]    word;
      logic [CheckCnt-1:0] syn;
      int unsigned         rounds;
      out_item_t           res;
      if (item.opcode == OP_LOAD) begin
        if (item.row_index < CheckCnt) rows[item.row_index] = item.data_word & WordMask;
        return;
      end
      word = item.data_word & WordMask;
      syn = syndrome(word);
      rounds = 0;
      while (syn != '0 && rounds < limit) begin
        word = flip_worst(word, syn);
        rounds++;
        syn = syndrome(word);
      end
      res.decoded_word = word;
      res.syndrome_clear = (syn == '0);
      res.iterations_used = rounds[IterW-1:0];
      awaited.push_back(res);
    endfunction

    task report(string msg);
      if (mismatches < MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result item with no decode waiting, word %h", got.decoded_word));
        return;
      end
      want = awaited.pop_front();
      if (got.decoded_word !== want.decoded_word)
        report($sformatf("decoded_word %h, predicted %h", got.decoded_word, want.decoded_word));
      if (got.syndrome_clear !== want.syndrome_clear)
        report($sformatf("syndrome_clear %b, predicted %b",
                         got.syndrome_clear, want.syndrome_clear));
      if (got.iterations_used !== want.iterations_used)
        report($sformatf("iterations_used %0d, predicted %0d",
                         got.iterations_used, want.iterations_used));
    endtask

    task flag_leftovers();
      while (awaited.size() != 0) begin
        report($sformatf("no result for decode predicted as %h", awaited[0].decoded_word));
        void'(awaited.pop_front());
      end
    endtask
  endclass

  // Every input of the block holds a known value from time zero.
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  // While set, neither side inserts gaps, so back-to-back items are seen too.
  bit          no_idle = 1'b0;
  int unsigned idle_cycles = 0;

  decode_scoreboard sb;

  ldpc_bit_flip_decoder #(
    .CODE_LENGTH(CodeLen),
    .CHECK_COUNT(CheckCnt)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Reset is asserted from time zero and released on a falling edge, once only.
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Any accepted item on any channel counts as progress for the watchdog.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("[%0t] watchdog: no handshake for %0d cycles", $time, StallLimit);
    $display("Some tests failed");
    $finish;
  end

  // Unless no_idle is set, the receiver draws a random stall before each result item,
  // then holds ready high until the item is taken.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
      sb.check_result(out_data);
    end
  end

  function automatic logic [DataW-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Sparse rows of even weight keep both the all-zero and the all-one word valid
  // codewords, so corrupted copies of them tend to decode back within a few rounds.
  function automatic logic [DataW-1:0] sparse_even_row();
    logic [DataW-1:0] row;
    int               weight;
    row = '0;
    weight = $urandom_range(2, 10);
    repeat (weight) row[$urandom_range(0, CodeLen - 1)] = 1'b1;
    if (^row) row[$urandom_range(0, CodeLen - 1)] ^= 1'b1;
    return row;
  endfunction

  function automatic logic [DataW-1:0] with_errors(logic [DataW-1:0] base, int count);
    repeat (count) base[$urandom_range(0, CodeLen - 1)] ^= 1'b1;
    return base;
  endfunction

  // Called on a falling edge and returns on the falling edge after acceptance.
  // With no gap drawn, valid simply stays high and only the payload changes.
  task automatic send_item(in_item_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (!in_ready);
    sb.note_input(item);
    @(negedge clk_i);
  endtask

  task automatic load_row(int idx, logic [DataW-1:0] bits);
    in_item_t item;
    item.opcode = OP_LOAD;
    item.row_index = RowIdxW'(idx);
    item.data_word = bits;
    send_item(item);
  endtask

  // The row index field is ignored by a decode, but random values keep its bits moving.
  task automatic decode_word(logic [DataW-1:0] bits);
    in_item_t item;
    item.opcode = OP_DECODE;
    item.row_index = RowIdxW'($urandom_range(0, CheckCnt - 1));
    item.data_word = bits;
    send_item(item);
  endtask

  task automatic load_matrix();
    for (int r = 0; r < CheckCnt; r++) load_row(r, sparse_even_row());
  endtask

  // Stops sending and waits until every predicted result has come back, plus a
  // short settle for a trailing load.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [IterW-1:0] value);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_limit(value);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                 pick;
    int                 phase_items;
    logic [DataW-1:0]   base;
    logic [IterW-1:0]   phase_limit;
    sb = new();
    @(posedge rst_ni);
    @(negedge clk_i);

    // Every row is loaded before the first decode. Row 0 covers all positions and
    // the last row ties the two end positions together.
    load_row(0, '1);
    for (int r = 1; r < CheckCnt - 1; r++) load_row(r, sparse_even_row());
    load_row(CheckCnt - 1, {1'b1, {(DataW - 2){1'b0}}, 1'b1});

    // Directed decodes at the reset limit: words that are already clear, single
    // errors at both ends of the word, a dense pattern and random noise.
    decode_word('0);
    decode_word('1);
    decode_word(64'h1);
    decode_word(64'h1 << (CodeLen - 1));
    decode_word(64'hAAAA_AAAA_AAAA_AAAA);
    decode_word(random_word());
    decode_word(with_errors('0, 3));

    // An all-zero row never becomes unsatisfied; reload both extreme indexes.
    load_row(CheckCnt - 1, '0);
    load_row(0, sparse_even_row());
    decode_word(with_errors('1, 1));

    // With a zero limit no flipping is done and the received word comes back.
    write_limit('0);
    decode_word(random_word());
    decode_word(with_errors('0, 1));
    decode_word('0);

    // A single round stops most corrupted words at the limit.
    write_limit(8'd1);
    decode_word(with_errors('0, 2));
    decode_word(random_word());

    write_limit('1);
    decode_word(with_errors('0, 1));
    decode_word(with_errors('1, 2));

    // Random phases. Each phase picks a limit, sometimes reloads the whole matrix,
    // and then mixes row loads with decodes. Most decodes are codewords with a
    // few errors, so they exercise real correction; the rest are clean codewords
    // and random noise that usually runs into the limit.
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin
          phase_limit = MAX_ITER_RESET;
        end
        1: begin
          phase_limit = '0;
        end
        2: begin
          phase_limit = '1;
        end
        3: begin
          phase_limit = 8'd1;
        end
        default: begin
          phase_limit = IterW'($urandom_range(2, 12));
        end
      endcase
      write_limit(phase_limit);
      no_idle = (phase % 4 == 3);
      if (phase % 3 == 0) load_matrix();
      // The largest limit makes undecodable words very slow, so that phase is short.
      phase_items = (phase_limit == '1) ? 12 : PhaseItems;
      for (int n = 0; n < phase_items; n++) begin
        // Hold the sender now and then until the decoder has drained completely.
        if (n == phase_items / 2 && phase % 2 == 1) wait_quiet();
        pick = $urandom_range(0, 99);
        base = $urandom_range(0, 1) ? '1 : '0;
        if (pick < 25) begin
          load_row($urandom_range(0, CheckCnt - 1), sparse_even_row());
        end else if (pick < 30) begin
          load_row($urandom_range(0, CheckCnt - 1), random_word());
        end else if (pick < 40) begin
          decode_word(base);
        end else if (pick < 85) begin
          decode_word(with_errors(base, $urandom_range(1, 3)));
        end else begin
          decode_word(random_word());
        end
      end
    end

    // Drain, then keep watching a while for stray result items.
    no_idle = 1'b0;
    wait_quiet();
    repeat (DrainCycles) @(negedge clk_i);
    sb.flag_leftovers();
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
